// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Capacity, count width, status codes and the word passed along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   // number of cells in the row
   localparam int CAPACITY = 16;
   // count must hold CAPACITY itself
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int ECOUNT_W = 5;

   // request action codes
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   // one held entry
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic      insert;   // enqueue into a non-full queue
      logic      shift;    // dequeue from a non-empty queue
      entry_type item;     // entry being inserted
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Holds one entry; on insert keeps, takes the new word or takes its
// upper neighbor's word; on dequeue takes its lower neighbor's word.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
   input  wire logic               clock,
   input  wire spq_pkg::cmd_type   cmd,
   input  wire logic               occupied,    // slot lies below the count
   input  wire logic               prev_keep,   // neighbor toward head stays
   input  wire spq_pkg::entry_type prev_entry,  // neighbor toward head
   input  wire spq_pkg::entry_type next_entry,  // neighbor toward tail
   output logic                    keep,
   output spq_pkg::entry_type      entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // entry stays put when it ranks at or above the incoming word
   assign keep = occupied && (entry_ff.prio >= cmd.item.prio);

   // next slot content
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (!keep) begin
            entry_in = prev_keep ? cmd.item : prev_entry;
         end
      end else if (cmd.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue on a row of cells
// Keeps up to CAPACITY entries sorted, highest priority at the head.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word: action (enqueue or dequeue), value, priority.
//   rsp_* returns one word per request: status, out_valid, the dequeued
//   value and priority (zero otherwise) and the count held afterwards.
//   Enqueue places the entry behind all entries of greater or equal
//   priority, so equal priorities leave first in, first out. Enqueue into
//   a full queue answers overflow; dequeue from an empty one underflow.
// Timing:
//   Every cell compares its priority with the incoming word in parallel and
//   loads from itself, the request or a neighbor in the same cycle.
//   The response is registered and appears in the cycle after accept.
//   One word per cycle is sustained while rsp_ready stays high.
// Reset: synchronous reset empties the queue and drops any pending response.
// Stall: the response register holds while rsp_ready is low; req_ready is
//   high only when that register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_action,
   input  wire logic signed [31:0] req_item_value,
   input  wire logic [7:0]         req_item_priority,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic                    rsp_out_valid,
   output logic signed [31:0]      rsp_out_value,
   output logic [7:0]              rsp_out_priority,
   output logic [4:0]              rsp_entry_count
);

   localparam int N = spq_pkg::CAPACITY;

   spq_pkg::count_type  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_out_valid_ff, rsp_out_valid_in;
   spq_pkg::entry_type  rsp_entry_ff, rsp_entry_in;
   spq_pkg::count_type  rsp_count_ff;

   logic                accept, full, empty;
   spq_pkg::cmd_type    cmd;
   logic [N-1:0]        occupied;
   logic [N-1:0]        keep;
   spq_pkg::entry_type  cells [N];

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == spq_pkg::count_type'(N));
   assign empty     = (count_ff == '0);

   // command to the row
   assign cmd.insert     = accept && (req_action == spq_pkg::ACT_ENQUEUE) && !full;
   assign cmd.shift      = accept && (req_action == spq_pkg::ACT_DEQUEUE) && !empty;
   assign cmd.item.value = req_item_value;
   assign cmd.item.prio  = req_item_priority;

   // cell row
   for (genvar i = 0; i < N; i++) begin : g_cell
      spq_pkg::entry_type prev_e, next_e;
      logic               prev_k;

      assign occupied[i] = (count_ff > spq_pkg::count_type'(i));

      if (i == 0) begin : g_head
         assign prev_k = 1'b1;
         assign prev_e = cmd.item;
      end else begin : g_body
         assign prev_k = keep[i-1];
         assign prev_e = cells[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign next_e = '0;
      end else begin : g_inner
         assign next_e = cells[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occupied[i]),
         .prev_keep  (prev_k),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .keep       (keep[i]),
         .entry      (cells[i])
      );
   end

   // count and response word
   always_comb begin
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = spq_pkg::ST_OK;
      rsp_out_valid_in = 1'b0;
      rsp_entry_in     = '0;
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_action == spq_pkg::ACT_ENQUEUE) begin
            if (full) begin
               rsp_status_in = spq_pkg::ST_OVERFLOW;
            end else begin
               count_in = count_ff + spq_pkg::count_type'(1);
            end
         end else begin
            if (empty) begin
               rsp_status_in = spq_pkg::ST_UNDERFLOW;
            end else begin
               count_in         = count_ff - spq_pkg::count_type'(1);
               rsp_out_valid_in = 1'b1;
               rsp_entry_in     = cells[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload loads only on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_out_valid_ff <= rsp_out_valid_in;
         rsp_entry_ff     <= rsp_entry_in;
         rsp_count_ff     <= count_in;
      end
   end

   // outputs; count field carries the low bits of the count
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_valid    = rsp_out_valid_ff;
   assign rsp_out_value    = rsp_entry_ff.value;
   assign rsp_out_priority = rsp_entry_ff.prio;
   assign rsp_entry_count  = spq_pkg::ECOUNT_W'(rsp_count_ff);

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::count_type'(N))
      else $error("count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + spq_pkg::count_type'(1))
      else $error("insert did not raise count");

   a_shift_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |=> rsp_valid_ff && rsp_out_valid_ff)
      else $error("dequeue gave no entry");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      occupied[1] |-> cells[0].prio >= cells[1].prio)
      else $error("head out of order");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_priority_queue_unit
// Directed table then biased random enqueue/dequeue traffic. A shadow queue
// predicts the response words of all but pinned rows; traffic runs under
// several idle/stall mixes, with two long receiver hold-offs backing up requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES = 10;

   // one response word as the bench sees it
   typedef struct packed {
      status_type                status;
      logic                      out_valid;
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
      logic [ECOUNT_W-1:0]       count;
   } queue_reply_t;

   // one line of the directed table; pinned rows carry a hand-typed reply
   typedef struct {
      logic                      action;
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
      bit                        pinned;
      queue_reply_t              reply;
   } stim_row_t;

   typedef struct {
      bit           pinned;
      queue_reply_t reply;
   } pin_t;

   localparam queue_reply_t NO_REPLY = '0;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_action;
   logic signed [31:0]        req_item_value;
   logic [7:0]                req_item_priority;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [1:0]                rsp_status;
   logic                      rsp_out_valid;
   logic signed [31:0]        rsp_out_value;
   logic [7:0]                rsp_out_priority;
   logic [4:0]                rsp_entry_count;

   // shadow copy of the queue contents, head at index 0
   logic signed [VALUE_W-1:0] shadow_value [CAPACITY];
   logic [PRIO_W-1:0]         shadow_prio [CAPACITY];
   int                        shadow_count;

   queue_reply_t              pending_replies[$];
   pin_t                      pinned_words[$];
   int                        fail_count;
   int                        cycle_count;

   // traffic shaping knobs: idle and stall in percent of cycles, hold-offs as a count
   int                        send_idle_pct;
   int                        recv_stall_pct;
   int                        hold_requests;

   stim_row_t                 directed_rows[24];

   sorted_priority_queue_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_entry_count   (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // apply one accepted word to the shadow queue and return its reply
   function automatic queue_reply_t apply_queue_op(logic act,
                                                   logic signed [VALUE_W-1:0] val,
                                                   logic [PRIO_W-1:0] pri);
      queue_reply_t r;
      int           pos;
      r = NO_REPLY;
      r.status = ST_OK;
      if (act == ACT_ENQUEUE) begin
         if (shadow_count >= CAPACITY) begin
            r.status = ST_OVERFLOW;
         end else begin
            // behind every entry of greater or equal priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] >= pri) pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_value[i] = shadow_value[i-1];
               shadow_prio[i]  = shadow_prio[i-1];
            end
            shadow_value[pos] = val;
            shadow_prio[pos]  = pri;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = ST_UNDERFLOW;
         end else begin
            r.out_valid = 1'b1;
            r.value     = shadow_value[0];
            r.prio      = shadow_prio[0];
            for (int i = 1; i < shadow_count; i++) begin
               shadow_value[i-1] = shadow_value[i];
               shadow_prio[i-1]  = shadow_prio[i];
            end
            shadow_count--;
         end
      end
      r.count = ECOUNT_W'(shadow_count);
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // cycle count and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response check first, then prediction for a newly accepted word
   always @(posedge clock) begin
      queue_reply_t want;
      queue_reply_t got;
      pin_t         pin;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_out_valid, rsp_out_value, rsp_out_priority,
                   rsp_entry_count};
            if (pending_replies.size() == 0) begin
               $error("response word with no request outstanding");
               fail_count++;
            end else begin
               want = pending_replies.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
               check_field("out_value", want.value, got.value);
               check_field("out_priority", 32'(want.prio), 32'(got.prio));
               check_field("entry_count", 32'(want.count), 32'(got.count));
            end
         end
         if (req_valid && req_ready) begin
            pin  = pinned_words.pop_front();
            want = apply_queue_op(req_action, req_item_value, req_item_priority);
            pending_replies.push_back(pin.pinned ? pin.reply : want);
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   initial begin
      int holds_served;
      int hold_left;
      holds_served = 0;
      hold_left    = 0;
      rsp_ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_served < hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // offer one word; entered and left at a falling edge
   task automatic send_word(logic act, logic signed [31:0] val, logic [7:0] pri,
                            bit pinned, queue_reply_t reply);
      pin_t pin;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      pin.pinned = pinned;
      pin.reply  = reply;
      pinned_words.push_back(pin);
      req_action        = act;
      req_item_value    = val;
      req_item_priority = pri;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // stimulus
   initial begin
      int                 phase_items [5];
      int                 phase_send [5];
      int                 phase_recv [5];
      int                 fill_level;
      bit                 filling;
      logic               act;
      logic [7:0]         pri;
      logic signed [31:0] val;

      phase_items = '{200, 150, 150, 150, 150};
      phase_send  = '{0, 84, 0, 34, 0};
      phase_recv  = '{0, 0, 84, 34, 0};

      directed_rows = '{
         // empty after reset
         '{ACT_DEQUEUE, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{ST_UNDERFLOW, 1'b0, 32'sd0, 8'd0, 5'd0}},
         // extremes of value and priority go in and come back out
         '{ACT_ENQUEUE, 32'h7FFF_FFFF, 8'd255, 1'b1, '{ST_OK, 1'b0, 32'sd0, 8'd0, 5'd1}},
         '{ACT_DEQUEUE, 32'h0000_0000, 8'd0, 1'b1, '{ST_OK, 1'b1, 32'h7FFF_FFFF, 8'd255, 5'd0}},
         '{ACT_ENQUEUE, 32'h8000_0000, 8'd0, 1'b1, '{ST_OK, 1'b0, 32'sd0, 8'd0, 5'd1}},
         '{ACT_DEQUEUE, 32'h5555_AAAA, 8'hA5, 1'b1, '{ST_OK, 1'b1, 32'h8000_0000, 8'd0, 5'd0}},
         '{ACT_DEQUEUE, 32'h0000_0000, 8'd0, 1'b1, '{ST_UNDERFLOW, 1'b0, 32'sd0, 8'd0, 5'd0}},
         // fill to capacity with ties and mixed priorities
         '{ACT_ENQUEUE, 32'sd1, 8'd5, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd2, 8'd5, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd3, 8'd9, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd4, 8'd0, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd5, 8'd255, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, -32'sd6, 8'd5, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd7, 8'd9, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd8, 8'd128, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd9, 8'd0, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd10, 8'd1, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd11, 8'd255, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd12, 8'd5, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd13, 8'd200, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd14, 8'd3, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd15, 8'd3, 1'b0, NO_REPLY},
         '{ACT_ENQUEUE, 32'sd16, 8'd5, 1'b0, NO_REPLY},
         // full: dropped with overflow
         '{ACT_ENQUEUE, 32'sd17, 8'd255, 1'b1, '{ST_OVERFLOW, 1'b0, 32'sd0, 8'd0, 5'd16}},
         '{ACT_DEQUEUE, 32'sd0, 8'd0, 1'b0, NO_REPLY}
      };

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ACT_ENQUEUE;
      req_item_value    = '0;
      req_item_priority = '0;
      fail_count        = 0;
      cycle_count       = 0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      hold_requests     = 0;
      shadow_count      = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         shadow_value[i] = '0;
         shadow_prio[i]  = '0;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].action, directed_rows[i].value,
                   directed_rows[i].prio, directed_rows[i].pinned,
                   directed_rows[i].reply);
      end

      // random traffic; fill and drain runs so both ends get hit
      fill_level = CAPACITY - 1;
      filling    = 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct  = phase_send[ph];
         recv_stall_pct = phase_recv[ph];
         for (int n = 0; n < phase_items[ph]; n++) begin
            // long receiver hold-off while words keep coming
            if (ph == 4 && (n == 10 || n == 90)) hold_requests++;
            if ($urandom_range(99) < 5) filling = ~filling;
            if (filling && fill_level >= CAPACITY && $urandom_range(2) == 0) filling = 1'b0;
            if (!filling && fill_level == 0 && $urandom_range(2) == 0) filling = 1'b1;
            act = ($urandom_range(99) < 85) ? (filling ? ACT_ENQUEUE : ACT_DEQUEUE)
                                            : (filling ? ACT_DEQUEUE : ACT_ENQUEUE);
            case ($urandom_range(3))
               0: pri = 8'($urandom_range(2));
               1: pri = $urandom_range(1) ? 8'd255 : 8'd0;
               default: pri = 8'($urandom);
            endcase
            val = $urandom;
            if (act == ACT_ENQUEUE) begin
               if (fill_level < CAPACITY) fill_level++;
            end else begin
               if (fill_level > 0) fill_level--;
            end
            send_word(act, val, pri, 1'b0, NO_REPLY);
         end
      end
      req_valid = 1'b0;

      // drain, then let the pipeline settle
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
